// ===== rtl/core/rrrl_pkg.sv =====
package rrrl_pkg;

    // Fixed field widths of the beats
    localparam int OP_W      = 2;
    localparam int PROC_ID_W = 16;
    localparam int OUT_ID_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd2;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [PROC_ID_W-1:0] proc_id;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] out_id;
        logic                out_valid;
        logic [STATUS_W-1:0] status;
        logic                list_empty;
        logic [COUNT_W-1:0]  entry_count;
    } out_beat_t;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_SCAN,
        UOP_ENQ_FIRST,
        UOP_ENQ_LINK_TAIL,
        UOP_ENQ_LINK_NEW,
        UOP_RD_HEAD,
        UOP_POP,
        UOP_RD_CUR_LINK,
        UOP_NEXT,
        UOP_WALK_START,
        UOP_WALK_STEP,
        UOP_UNLINK,
        UOP_RESULT
    } uop_t;

    // Which result form the output beat takes
    typedef enum logic [1:0] {
        RS_CURSOR,
        RS_FULL,
        RS_EMPTY,
        RS_POPPED
    } rsel_t;

    typedef struct packed {
        uop_t  uop;
        rsel_t rsel;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            count_full;
        logic            cur_is_head;
        logic            scan_hit;
        logic            walk_hit;
        logic            walk_last;
        logic            out_free;
    } sts_t;

endpackage

// ===== rtl/core/rrrl_ram.sv =====
module rrrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rrrl_dpath.sv =====
module rrrl_dpath #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrrl_pkg::cmd_t      cmd,
    output rrrl_pkg::sts_t      sts,
    input  rrrl_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rrrl_pkg::out_beat_t m_data
);

    import rrrl_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SW     = (ID_BITS < PROC_ID_W) ? ID_BITS : PROC_ID_W;
    localparam int LANES  = 8;
    localparam int LANE_W = $clog2(LANES);
    localparam int NCHUNK = (DEPTH + LANES - 1) / LANES;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    // List state
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] cursor_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DEPTH-1:0] free_reg;
    logic             m_valid_reg;

    // Working registers
    logic [PTR_W-1:0] prev_reg;
    logic [PTR_W-1:0] new_slot_reg;
    logic [PTR_W-1:0] steps_reg;
    logic [CW-1:0]    scan_reg;
    logic [OP_W-1:0]  op_reg;
    logic [SW-1:0]    pid_reg;
    logic [SW-1:0]    popped_reg;
    out_beat_t        m_data_reg;
    out_beat_t        result;

    // Memory ports
    logic             id_we;
    logic [PTR_W-1:0] id_waddr;
    logic [SW-1:0]    id_wdata;
    logic [PTR_W-1:0] id_raddr;
    logic [SW-1:0]    id_rdata;
    logic             lk_we;
    logic [PTR_W-1:0] lk_waddr;
    logic [PTR_W-1:0] lk_wdata;
    logic [PTR_W-1:0] lk_raddr;
    logic [PTR_W-1:0] lk_rdata;

    // Free slot search, eight slots a cycle
    logic [NCHUNK*LANES-1:0] free_pad;
    logic [LANES-1:0]        chunk;
    logic [LANE_W-1:0]       lane;
    logic                    lane_hit;
    logic [CW+LANE_W-1:0]    scan_slot_wide;

    logic multi;
    logic has_id;
    logic out_free;
    logic walk_hit;

    rrrl_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_id_ram (
        .aclk  (aclk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    rrrl_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_link_ram (
        .aclk  (aclk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    always_comb begin
        free_pad = '0;
        free_pad[DEPTH-1:0] = free_reg;
        chunk = free_pad[{scan_reg, {LANE_W{1'b0}}} +: LANES];
        lane = '0;
        lane_hit = 1'b0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (chunk[i]) begin
                lane = LANE_W'(i);
                lane_hit = 1'b1;
            end
        end
        scan_slot_wide = {scan_reg, lane};
    end

    assign multi    = count_reg > CNT_W'(1);
    assign has_id   = count_reg != '0;
    assign out_free = !m_valid_reg || m_ready;
    assign walk_hit = lk_rdata == cursor_reg;

    // Memory address and write selection
    always_comb begin
        id_we    = 1'b0;
        id_waddr = new_slot_reg;
        id_wdata = pid_reg;
        id_raddr = cursor_reg;
        lk_we    = 1'b0;
        lk_waddr = new_slot_reg;
        lk_wdata = new_slot_reg;
        lk_raddr = cursor_reg;
        case (cmd.uop)
            UOP_ENQ_FIRST: begin
                id_we = 1'b1;
                lk_we = 1'b1;
            end
            UOP_ENQ_LINK_TAIL: begin
                id_we    = 1'b1;
                lk_we    = 1'b1;
                lk_waddr = tail_reg;
            end
            UOP_ENQ_LINK_NEW: begin
                lk_we    = 1'b1;
                lk_wdata = head_reg;
            end
            UOP_RD_HEAD: begin
                id_raddr = head_reg;
                lk_raddr = head_reg;
            end
            UOP_POP: begin
                // close the ring over the removed head
                lk_we    = multi;
                lk_waddr = tail_reg;
                lk_wdata = lk_rdata;
            end
            UOP_WALK_START: begin
                lk_raddr = head_reg;
            end
            UOP_WALK_STEP: begin
                lk_raddr = lk_rdata;
            end
            UOP_UNLINK: begin
                lk_we    = 1'b1;
                lk_waddr = prev_reg;
                lk_wdata = lk_rdata;
            end
            default: begin
            end
        endcase
    end

    // Result beat
    always_comb begin
        result.list_empty  = !has_id;
        result.entry_count = COUNT_W'(count_reg);
        result.out_id      = has_id ? OUT_ID_W'(id_rdata) : '0;
        result.out_valid   = has_id;
        result.status      = ST_OK;
        case (cmd.rsel)
            RS_CURSOR: begin
            end
            RS_FULL: begin
                result.status = ST_FULL;
            end
            RS_EMPTY: begin
                result.out_id    = '0;
                result.out_valid = 1'b0;
                result.status    = ST_EMPTY;
            end
            RS_POPPED: begin
                result.out_id    = OUT_ID_W'(popped_reg);
                result.out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            cursor_reg  <= '0;
            count_reg   <= '0;
            free_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.uop == UOP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.uop)
                UOP_ENQ_FIRST: begin
                    head_reg               <= new_slot_reg;
                    tail_reg               <= new_slot_reg;
                    cursor_reg             <= new_slot_reg;
                    free_reg[new_slot_reg] <= 1'b0;
                    count_reg              <= count_reg + CNT_W'(1);
                end
                UOP_ENQ_LINK_TAIL: begin
                    free_reg[new_slot_reg] <= 1'b0;
                end
                UOP_ENQ_LINK_NEW: begin
                    tail_reg  <= new_slot_reg;
                    count_reg <= count_reg + CNT_W'(1);
                end
                UOP_POP: begin
                    free_reg[head_reg] <= 1'b1;
                    if (!multi) begin
                        head_reg   <= '0;
                        tail_reg   <= '0;
                        cursor_reg <= '0;
                        count_reg  <= '0;
                    end else begin
                        if (cursor_reg == head_reg) begin
                            cursor_reg <= lk_rdata;
                        end
                        head_reg  <= lk_rdata;
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                UOP_NEXT: begin
                    cursor_reg <= lk_rdata;
                end
                UOP_UNLINK: begin
                    if (cursor_reg == tail_reg) begin
                        tail_reg <= prev_reg;
                    end
                    free_reg[cursor_reg] <= 1'b1;
                    cursor_reg <= lk_rdata;
                    count_reg  <= count_reg - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and output payload
    always_ff @(posedge aclk) begin
        case (cmd.uop)
            UOP_LOAD: begin
                op_reg   <= s_data.operation;
                pid_reg  <= s_data.proc_id[SW-1:0];
                scan_reg <= '0;
            end
            UOP_SCAN: begin
                if (lane_hit) begin
                    new_slot_reg <= scan_slot_wide[PTR_W-1:0];
                end else begin
                    scan_reg <= scan_reg + CW'(1);
                end
            end
            UOP_POP: begin
                popped_reg <= id_rdata;
            end
            UOP_WALK_START: begin
                prev_reg  <= head_reg;
                steps_reg <= '0;
            end
            UOP_WALK_STEP: begin
                if (!walk_hit) begin
                    prev_reg  <= lk_rdata;
                    steps_reg <= steps_reg + PTR_W'(1);
                end
            end
            UOP_RESULT: begin
                m_data_reg <= result;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.op          = op_reg;
        sts.count_zero  = !has_id;
        sts.count_full  = count_reg == CNT_W'(DEPTH);
        sts.cur_is_head = cursor_reg == head_reg;
        sts.scan_hit    = lane_hit;
        sts.walk_hit    = walk_hit;
        sts.walk_last   = steps_reg == PTR_W'(DEPTH - 1);
        sts.out_free    = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/rrrl_ctrl.sv =====
module rrrl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output rrrl_pkg::cmd_t cmd,
    input  rrrl_pkg::sts_t sts
);

    import rrrl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ENQ_A,
        S_ENQ_B,
        S_POP_RD,
        S_POP,
        S_NXT_RD,
        S_NXT,
        S_WALK_START,
        S_WALK,
        S_DEL_RD,
        S_UNLINK,
        S_OUT_RD,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    rsel_t  rsel_reg, rsel_next;
    uop_t   uop;

    // Next state and micro-op
    always_comb begin
        state_next = state_reg;
        rsel_next  = rsel_reg;
        uop        = UOP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    uop        = UOP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                rsel_next = RS_CURSOR;
                if (sts.op == OP_ENQ) begin
                    if (sts.count_full) begin
                        rsel_next  = RS_FULL;
                        state_next = S_OUT_RD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else if (sts.count_zero) begin
                    rsel_next  = RS_EMPTY;
                    state_next = S_FINISH;
                end else begin
                    case (sts.op)
                        OP_DEQ: begin
                            rsel_next  = RS_POPPED;
                            state_next = S_POP_RD;
                        end
                        OP_NEXT: begin
                            state_next = S_NXT_RD;
                        end
                        default: begin
                            // delete-current: the head needs no walk
                            state_next = sts.cur_is_head ? S_POP_RD : S_WALK_START;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                uop = UOP_SCAN;
                if (sts.scan_hit) begin
                    state_next = S_ENQ_A;
                end
            end
            S_ENQ_A: begin
                if (sts.count_zero) begin
                    uop        = UOP_ENQ_FIRST;
                    state_next = S_OUT_RD;
                end else begin
                    uop        = UOP_ENQ_LINK_TAIL;
                    state_next = S_ENQ_B;
                end
            end
            S_ENQ_B: begin
                uop        = UOP_ENQ_LINK_NEW;
                state_next = S_OUT_RD;
            end
            S_POP_RD: begin
                uop        = UOP_RD_HEAD;
                state_next = S_POP;
            end
            S_POP: begin
                uop        = UOP_POP;
                state_next = (rsel_reg == RS_POPPED) ? S_FINISH : S_OUT_RD;
            end
            S_NXT_RD: begin
                uop        = UOP_RD_CUR_LINK;
                state_next = S_NXT;
            end
            S_NXT: begin
                uop        = UOP_NEXT;
                state_next = S_OUT_RD;
            end
            S_WALK_START: begin
                uop        = UOP_WALK_START;
                state_next = S_WALK;
            end
            S_WALK: begin
                uop = UOP_WALK_STEP;
                if (sts.walk_hit) begin
                    state_next = S_DEL_RD;
                end else if (sts.walk_last) begin
                    // cursor not on the ring: leave the list alone
                    state_next = S_OUT_RD;
                end
            end
            S_DEL_RD: begin
                uop        = UOP_RD_CUR_LINK;
                state_next = S_UNLINK;
            end
            S_UNLINK: begin
                uop        = UOP_UNLINK;
                state_next = S_OUT_RD;
            end
            S_OUT_RD: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    uop        = UOP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rsel_reg  <= RS_CURSOR;
        end else begin
            state_reg <= state_next;
            rsel_reg  <= rsel_next;
        end
    end

    assign s_ready  = state_reg == S_IDLE;
    assign cmd.uop  = uop;
    assign cmd.rsel = rsel_reg;

endmodule

// ===== rtl/core/round_robin_ready_list.sv =====
// Round-robin ready list: a ring of up to DEPTH process IDs kept in linked
// slots, with a cursor that steps round-robin. Each input beat is enqueue,
// dequeue, move-next or delete-current and yields exactly one result beat.
// IDs and links live in two single-port-write, registered-read memories, so
// every list step waits on a registered memory read. Enqueue runs a
// free-slot search, which looks at eight slots per cycle. Delete-current of
// a non-head entry walks the link memory from the head one slot per cycle
// to find the predecessor. A new beat is taken the cycle after the previous
// result is loaded into the output register, even while that result waits
// for m_ready; a result that is ready while the one before it still waits
// holds the block until m_ready.
module round_robin_ready_list #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrrl_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rrrl_pkg::out_beat_t m_data
);

    import rrrl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rrrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    rrrl_dpath #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/rrrl_checker.sv =====
module rrrl_checker #(
    parameter int DEPTH = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rrrl_pkg::out_beat_t m_data
);

    import rrrl_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // An underflow reports an empty list and no ID
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            !m_data.out_valid && m_data.out_id == '0 && m_data.list_empty
            && m_data.entry_count == '0)
        else $error("underflow beat malformed");

    // Full reports the cursor ID with the list at capacity
    a_full_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |->
            m_data.out_valid && !m_data.list_empty
            && m_data.entry_count == COUNT_W'(DEPTH))
        else $error("full beat malformed");

    // No ID without out_valid
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_id == '0)
        else $error("out_id set without out_valid");

endmodule

bind round_robin_ready_list rrrl_checker #(.DEPTH(DEPTH)) u_rrrl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/round_robin_ready_list_tb.sv =====
module round_robin_ready_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrrl_pkg::*;

    localparam int DEPTH      = 16;
    localparam int ID_BITS    = 16;
    localparam int RAND_BEATS = 1300;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AT    = 5000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;

    // Random segment flavors
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    round_robin_ready_list #(
        .DEPTH  (DEPTH),
        .ID_BITS(ID_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Shadow copy of the ring
    logic [ID_BITS-1:0] ring_id   [DEPTH];
    logic [3:0]         ring_link [DEPTH];
    logic [DEPTH-1:0]   ring_free = '1;
    logic [3:0]         ring_head = '0;
    logic [3:0]         ring_tail = '0;
    logic [3:0]         ring_cur  = '0;
    logic [4:0]         ring_fill = '0;

    in_beat_t  stim_q[$];
    out_beat_t ring_answers[$];

    int cycle_count = 0;
    int hold_left   = 0;
    int tx_gap      = 0;
    int rx_gap      = 0;
    int beats_in    = 0;
    int results_seen = 0;
    int err_count   = 0;
    int op_hits[4]  = '{0, 0, 0, 0};
    int full_hits   = 0;
    int empty_hits  = 0;
    int peak_fill   = 0;

    // Unlink the head entry; ring must hold at least one entry
    function automatic logic [ID_BITS-1:0] ring_pop();
        logic [ID_BITS-1:0] id;
        id = ring_id[ring_head];
        ring_free[ring_head] = 1'b1;
        if (ring_fill <= 1) begin
            ring_fill = '0;
            ring_head = '0;
            ring_tail = '0;
            ring_cur  = '0;
        end else begin
            if (ring_cur == ring_head) ring_cur = ring_link[ring_head];
            ring_head = ring_link[ring_head];
            ring_link[ring_tail] = ring_head;
            ring_fill--;
        end
        return id;
    endfunction

    // Apply one operation to the shadow ring and build the result beat it owes
    function automatic out_beat_t ring_step(in_beat_t b);
        out_beat_t  r;
        logic [3:0] s;
        logic [3:0] prev;
        logic [3:0] nx;
        logic       found;
        logic       show_cur;
        int         i;
        r = '0;
        show_cur = 1'b1;
        op_hits[b.operation]++;
        if (b.operation == OP_ENQ) begin
            if (ring_fill == DEPTH) begin
                r.status = ST_FULL;
                full_hits++;
            end else begin
                // lowest free slot wins
                s = '0;
                for (i = DEPTH - 1; i >= 0; i--) begin
                    if (ring_free[i]) s = i[3:0];
                end
                ring_free[s] = 1'b0;
                ring_id[s] = b.proc_id[ID_BITS-1:0];
                if (ring_fill == 0) begin
                    ring_head = s;
                    ring_tail = s;
                    ring_cur  = s;
                    ring_link[s] = s;
                end else begin
                    ring_link[ring_tail] = s;
                    ring_tail = s;
                    ring_link[s] = ring_head;
                end
                ring_fill++;
            end
        end else if (ring_fill == 0) begin
            r.status = ST_EMPTY;
            show_cur = 1'b0;
            empty_hits++;
        end else if (b.operation == OP_DEQ) begin
            r.out_id = ring_pop();
            r.out_valid = 1'b1;
            show_cur = 1'b0;
        end else if (b.operation == OP_NEXT) begin
            ring_cur = ring_link[ring_cur];
        end else if (ring_cur == ring_head) begin
            void'(ring_pop());
        end else begin
            // find the predecessor of the cursor entry
            prev = ring_head;
            found = 1'b0;
            for (i = 0; i < DEPTH && !found; i++) begin
                nx = ring_link[prev];
                if (nx == ring_cur) found = 1'b1;
                else prev = nx;
            end
            if (found) begin
                ring_link[prev] = ring_link[ring_cur];
                if (ring_cur == ring_tail) ring_tail = prev;
                ring_free[ring_cur] = 1'b1;
                ring_cur = ring_link[prev];
                ring_fill--;
            end
        end
        if (show_cur && ring_fill > 0) begin
            r.out_id = ring_id[ring_cur];
            r.out_valid = 1'b1;
        end
        r.list_empty = (ring_fill == 0);
        r.entry_count = ring_fill;
        if (ring_fill > peak_fill) peak_fill = ring_fill;
        return r;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, logic [PROC_ID_W-1:0] id);
        in_beat_t b;
        b.operation = op;
        b.proc_id = id;
        stim_q.push_back(b);
    endtask

    task automatic note_mismatch(string what, out_beat_t exp_b, out_beat_t got_b);
        err_count++;
        if (err_count <= 10) begin
            $display({"[%0t] %s: exp id=%h v=%b st=%0d empty=%b cnt=%0d,",
                      " got id=%h v=%b st=%0d empty=%b cnt=%0d"},
                     $realtime, what, exp_b.out_id, exp_b.out_valid, exp_b.status,
                     exp_b.list_empty, exp_b.entry_count, got_b.out_id, got_b.out_valid,
                     got_b.status, got_b.list_empty, got_b.entry_count);
        end
    endtask

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // One long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (cycle_count == HOLD_AT) begin
            hold_left <= HOLD_LEN;
        end
    end

    // Driver: predicts on every accepted beat, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                ring_answers.push_back(ring_step(s_data));
                beats_in++;
                if (stim_q.size() >= QUIET_TAIL && (beats_in % 256) >= 64 &&
                    $urandom_range(0, 4) == 0) begin
                    tx_gap = $urandom_range(1, 15);
                end
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    s_data <= stim_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat, then decides m_ready for the next cycle
    always @(posedge aclk) begin
        out_beat_t exp_b;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (ring_answers.size() == 0) begin
                    note_mismatch("unexpected result beat", '0, m_data);
                end else begin
                    exp_b = ring_answers.pop_front();
                    if (m_data.out_id !== exp_b.out_id ||
                        m_data.out_valid !== exp_b.out_valid ||
                        m_data.status !== exp_b.status ||
                        m_data.list_empty !== exp_b.list_empty ||
                        m_data.entry_count !== exp_b.entry_count) begin
                        note_mismatch("result mismatch", exp_b, m_data);
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (stim_q.size() >= QUIET_TAIL && (results_seen % 200) >= 50 &&
                         $urandom_range(0, 6) == 0) begin
                rx_gap = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Timeout
    initial begin
        wait (cycle_count >= CYCLE_CAP);
        $display("round_robin_ready_list_tb: done, errors");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        int             rand_left;
        int             seg_mode;
        int             seg_len;
        int             k;
        int             pick;
        int             id_pick;
        logic [OP_W-1:0] op;
        logic [PROC_ID_W-1:0] id;

        // empty-list operations
        queue_op(OP_DEQ, 16'h0000);
        queue_op(OP_NEXT, 16'hFFFF);
        queue_op(OP_DEL, 16'h0000);
        // first entry takes the cursor, deleting it empties the list
        queue_op(OP_ENQ, 16'hFFFF);
        queue_op(OP_DEL, 16'h0000);
        // cursor walks and wraps tail to head
        queue_op(OP_ENQ, 16'h0000);
        queue_op(OP_ENQ, 16'hFFFF);
        queue_op(OP_ENQ, 16'hA5A5);
        queue_op(OP_NEXT, 16'h0000);
        queue_op(OP_NEXT, 16'h0000);
        queue_op(OP_NEXT, 16'h0000);
        // dequeue with cursor on head: cursor follows new head
        queue_op(OP_DEQ, 16'h0000);
        // delete the tail entry under the cursor
        queue_op(OP_NEXT, 16'h0000);
        queue_op(OP_DEL, 16'h0000);
        // freed slots get reused, then a middle delete
        queue_op(OP_ENQ, 16'h5A5A);
        queue_op(OP_NEXT, 16'h0000);
        queue_op(OP_ENQ, 16'h1234);
        queue_op(OP_DEL, 16'h0000);
        queue_op(OP_DEQ, 16'h0000);
        queue_op(OP_DEQ, 16'h0000);
        queue_op(OP_DEQ, 16'h0000);

        // Random segments lean toward filling, draining or mixing
        rand_left = RAND_BEATS;
        while (rand_left > 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 60);
            for (k = 0; k < seg_len && rand_left > 0; k++) begin
                pick = $urandom_range(0, 99);
                case (seg_mode)
                    MODE_FILL: begin
                        op = (pick < 70) ? OP_ENQ : (pick < 85) ? OP_NEXT :
                             (pick < 95) ? OP_DEL : OP_DEQ;
                    end
                    MODE_DRAIN: begin
                        op = (pick < 15) ? OP_ENQ : (pick < 30) ? OP_NEXT :
                             (pick < 65) ? OP_DEL : OP_DEQ;
                    end
                    default: begin
                        op = (pick < 30) ? OP_ENQ : (pick < 60) ? OP_NEXT :
                             (pick < 80) ? OP_DEL : OP_DEQ;
                    end
                endcase
                id_pick = $urandom_range(0, 9);
                id = (id_pick == 0) ? 16'hFFFF : (id_pick == 1) ? 16'h0000 :
                     PROC_ID_W'($urandom_range(0, 65535));
                queue_op(op, id);
                rand_left--;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (ring_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (ring_answers.size() != 0) begin
            note_mismatch("result never arrived", ring_answers[0], '0);
        end

        $display("ran %0d beats: %0d enqueue, %0d dequeue, %0d move-next, %0d delete-current",
                 beats_in, op_hits[OP_ENQ], op_hits[OP_DEQ], op_hits[OP_NEXT],
                 op_hits[OP_DEL]);
        $display("%0d full rejects, %0d empty-list ops, peak fill %0d, %0d results, %0d errors",
                 full_hits, empty_hits, peak_fill, results_seen, err_count);
        if (err_count == 0) begin
            $display("round_robin_ready_list_tb: done, clean");
        end else begin
            $display("round_robin_ready_list_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rrrl_pkg.sv
rtl/core/rrrl_ram.sv
rtl/core/rrrl_dpath.sv
rtl/core/rrrl_ctrl.sv
rtl/core/round_robin_ready_list.sv
rtl/core/rrrl_checker.sv
tb/round_robin_ready_list_tb.sv
